[sv/agr_pkg.sv]
// ----------------------------------------------------------------------------
// agr_pkg
// Shared types and constants of the audio gain ramp: field widths, command
// codes, Q16 gain scale, ramp length and the sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package agr_pkg;

  localparam int unsigned RAMP_FRAMES   = 256;
  localparam int unsigned GAIN_FRAC     = 16;
  localparam int unsigned GAIN_ONE      = 1 << GAIN_FRAC;
  localparam int unsigned ROUND_BIAS    = 5000;
  localparam int unsigned PERCENT_SCALE = 10000;
  localparam int unsigned PERCENT_MAX   = 100;
  localparam int unsigned MAX_CHANNELS  = 8;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned PCT_W    = 7;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned GAIN_W   = GAIN_FRAC + 1;
  localparam int unsigned CC_W     = 4;
  localparam int unsigned POS_W    = $clog2(MAX_CHANNELS);
  localparam int unsigned FRAMES_W = $clog2(RAMP_FRAMES + 1);

  localparam int unsigned PP_W     = 2 * PCT_W;
  localparam int unsigned NUM_W    =
      $clog2((PERCENT_MAX - 1) * (PERCENT_MAX - 1) * GAIN_ONE + ROUND_BIAS + 1);
  localparam int unsigned SCALE_W  = $clog2(PERCENT_SCALE + 1);
  localparam int unsigned DVSR_W   = (FRAMES_W > SCALE_W) ? FRAMES_W : SCALE_W;
  localparam int unsigned CNT_W    = $clog2(NUM_W + 1);
  localparam int unsigned PROD_W   = SAMPLE_W + GAIN_W;
  localparam int unsigned ACC_W    = PROD_W + 1;

  localparam int unsigned APB_DW   = 32;
  localparam int unsigned APB_AW   = 3;

  localparam logic [CMD_W-1:0] CMD_INIT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TARGET = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd2;

  localparam logic [CC_W-1:0] CC_RESET = 4'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GDIV,
    ST_RDIV,
    ST_MUL
  } state_e;

endpackage

`default_nettype wire

[sv/audio_gain_ramp.sv]
// ----------------------------------------------------------------------------
// audio_gain_ramp
// Volume gain stage for interleaved signed 16-bit audio with a square-law
// percent-to-gain map and a linear per-frame gain ramp.
// ----------------------------------------------------------------------------
// An audio sample is loaded on its transfer, then goes through a
// bit-serial shift-add multiply over the 17 gain bits and is rounded into
// the output register once that register is free. On the first channel of
// a frame while a ramp runs, the per-frame step first goes through a
// bit-serial restoring divider (17 steps, then the gain update). A volume
// command with a percent of 0 or 100 and above is applied directly; any
// other percent goes through the same divider for 30 steps. The next item
// is taken while a finished result still waits in the output register.
`default_nettype none

module audio_gain_ramp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,

  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [agr_pkg::APB_AW-1:0]    paddr,
  input  wire logic [agr_pkg::APB_DW-1:0]    pwdata,
  output logic      [agr_pkg::APB_DW-1:0]    prdata,
  output logic                               pready,

  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [agr_pkg::CMD_W-1:0]     command_i,
  input  wire logic [agr_pkg::PCT_W-1:0]     percent_i,
  input  wire logic signed [agr_pkg::SAMPLE_W-1:0] sample_in_i,

  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic signed [agr_pkg::SAMPLE_W-1:0] sample_out_o,
  output logic      [agr_pkg::GAIN_W-1:0]    gain_now_o,
  output logic                               ramp_active_o
);

  localparam int unsigned GW = agr_pkg::GAIN_W;
  localparam int unsigned SW = agr_pkg::SAMPLE_W;
  localparam int unsigned NW = agr_pkg::NUM_W;
  localparam int unsigned DW = agr_pkg::DVSR_W;
  localparam int unsigned FW = agr_pkg::FRAMES_W;
  localparam int unsigned CW = agr_pkg::CNT_W;
  localparam int unsigned PW = agr_pkg::PROD_W;
  localparam int unsigned AW = agr_pkg::ACC_W;

  agr_pkg::state_e               state_q, state_d;
  logic [GW-1:0]                 cur_q, cur_d;
  logic [GW-1:0]                 tgt_q, tgt_d;
  logic [FW-1:0]                 fl_q, fl_d;
  logic [agr_pkg::POS_W-1:0]     pos_q, pos_d;
  logic [agr_pkg::CC_W-1:0]      cc_q, cc_d;
  logic [CW-1:0]                 cnt_q, cnt_d;
  logic                          out_valid_q, out_valid_d;

  logic [NW-1:0]                 rq_q, rq_d;
  logic [DW-1:0]                 rem_q, rem_d;
  logic [DW-1:0]                 dvsr_q, dvsr_d;
  logic [AW-1:0]                 acc_q, acc_d;
  logic [SW-1:0]                 smag_q, smag_d;
  logic                          sneg_q, sneg_d;
  logic                          dneg_q, dneg_d;
  logic [agr_pkg::CMD_W-1:0]     cmd_q, cmd_d;

  logic [SW-1:0]                 sout_q, sout_d;
  logic [GW-1:0]                 gout_q, gout_d;
  logic                          rout_q, rout_d;

  // divider step
  logic [DW:0]                   div_sh;
  logic                          div_ge;
  logic [DW:0]                   div_diff;
  logic [NW-1:0]                 rq_step;
  logic [DW-1:0]                 rem_step;

  // multiplier step
  logic [GW-1:0]                 mul_sum;
  logic [AW-1:0]                 acc_step;
  logic [PW-1:0]                 prod_rnd;
  logic [GW-1:0]                 res_mag;
  logic [GW-1:0]                 res_val;

  // misc
  logic                          cfg_wr;
  logic                          in_xfer;
  logic                          out_free;
  logic [agr_pkg::PP_W-1:0]      pct_sq;
  logic [NW-1:0]                 gain_num;
  logic [GW:0]                   delta;
  logic [GW-1:0]                 dmag;
  logic [GW-1:0]                 new_cur;
  logic [FW-1:0]                 fl_dec;
  logic [agr_pkg::CC_W-1:0]      eff_cc;
  logic [agr_pkg::CC_W-1:0]      pos_inc;
  logic                          apply_en;
  logic [GW-1:0]                 apply_g;
  logic [agr_pkg::CMD_W-1:0]     apply_cmd;

  assign pready      = 1'b1;
  assign cfg_wr      = psel && penable && pwrite && !paddr[agr_pkg::APB_AW-1];
  assign prdata      = paddr[agr_pkg::APB_AW-1] ? '0 :
                       {{(agr_pkg::APB_DW-agr_pkg::CC_W){1'b0}}, cc_q};

  assign in_ready_o  = (state_q == agr_pkg::ST_IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign sample_out_o  = sout_q;
  assign gain_now_o    = gout_q;
  assign ramp_active_o = rout_q;

  assign div_sh   = {rem_q, rq_q[NW-1]};
  assign div_ge   = (div_sh >= {1'b0, dvsr_q});
  assign div_diff = div_sh - {1'b0, dvsr_q};
  assign rem_step = div_ge ? div_diff[DW-1:0] : div_sh[DW-1:0];
  assign rq_step  = {rq_q[NW-2:0], div_ge};

  assign mul_sum  = {1'b0, acc_q[PW-1:GW]} + (acc_q[0] ? {1'b0, smag_q} : '0);
  assign acc_step = {1'b0, mul_sum, acc_q[GW-1:1]};
  assign prod_rnd = acc_q[PW-1:0] + PW'(agr_pkg::GAIN_ONE / 2);
  assign res_mag  = prod_rnd[PW-1:agr_pkg::GAIN_FRAC];
  assign res_val  = sneg_q ? (GW'(0) - res_mag) : res_mag;

  assign pct_sq   = agr_pkg::PP_W'(percent_i) * agr_pkg::PP_W'(percent_i);
  assign gain_num = {pct_sq, agr_pkg::GAIN_FRAC'(0)} + NW'(agr_pkg::ROUND_BIAS);

  assign delta    = {1'b0, tgt_q} - {1'b0, cur_q};
  assign dmag     = delta[GW] ? GW'(~delta + 1'b1) : delta[GW-1:0];
  assign new_cur  = dneg_q ? (cur_q - rq_q[GW-1:0]) : (cur_q + rq_q[GW-1:0]);
  assign fl_dec   = fl_q - 1'b1;

  assign eff_cc   = (cc_q == '0) ? agr_pkg::CC_W'(1) :
                    (cc_q > agr_pkg::CC_W'(agr_pkg::MAX_CHANNELS)) ?
                    agr_pkg::CC_W'(agr_pkg::MAX_CHANNELS) : cc_q;
  assign pos_inc  = {1'b0, pos_q} + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= agr_pkg::ST_IDLE;
      cur_q       <= GW'(agr_pkg::GAIN_ONE);
      tgt_q       <= GW'(agr_pkg::GAIN_ONE);
      fl_q        <= '0;
      pos_q       <= '0;
      cc_q        <= agr_pkg::CC_RESET;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      tgt_q       <= tgt_d;
      fl_q        <= fl_d;
      pos_q       <= pos_d;
      cc_q        <= cc_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rq_q   <= rq_d;
    rem_q  <= rem_d;
    dvsr_q <= dvsr_d;
    acc_q  <= acc_d;
    smag_q <= smag_d;
    sneg_q <= sneg_d;
    dneg_q <= dneg_d;
    cmd_q  <= cmd_d;
    sout_q <= sout_d;
    gout_q <= gout_d;
    rout_q <= rout_d;
  end

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    tgt_d       = tgt_q;
    fl_d        = fl_q;
    pos_d       = pos_q;
    cc_d        = cfg_wr ? pwdata[agr_pkg::CC_W-1:0] : cc_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    rq_d        = rq_q;
    rem_d       = rem_q;
    dvsr_d      = dvsr_q;
    acc_d       = acc_q;
    smag_d      = smag_q;
    sneg_d      = sneg_q;
    dneg_d      = dneg_q;
    cmd_d       = cmd_q;
    sout_d      = sout_q;
    gout_d      = gout_q;
    rout_d      = rout_q;
    apply_en    = 1'b0;
    apply_g     = '0;
    apply_cmd   = cmd_q;

    unique case (state_q)
      agr_pkg::ST_IDLE: begin
        if (in_xfer) begin
          case (command_i) inside
            agr_pkg::CMD_INIT, agr_pkg::CMD_TARGET: begin
              cmd_d = command_i;
              if (percent_i == '0) begin
                apply_en  = 1'b1;
                apply_g   = '0;
                apply_cmd = command_i;
              end else if (percent_i >= agr_pkg::PCT_W'(agr_pkg::PERCENT_MAX)) begin
                apply_en  = 1'b1;
                apply_g   = GW'(agr_pkg::GAIN_ONE);
                apply_cmd = command_i;
              end else begin
                rq_d    = gain_num;
                rem_d   = '0;
                dvsr_d  = DW'(agr_pkg::PERCENT_SCALE);
                cnt_d   = CW'(NW);
                state_d = agr_pkg::ST_GDIV;
              end
            end
            agr_pkg::CMD_SAMPLE: begin
              sneg_d = sample_in_i[SW-1];
              smag_d = sample_in_i[SW-1] ? (SW'(0) - sample_in_i) : sample_in_i;
              pos_d  = (pos_inc >= eff_cc) ? '0 : pos_inc[agr_pkg::POS_W-1:0];
              if (pos_q == '0 && fl_q != '0) begin
                rq_d    = {dmag, (NW-GW)'(0)};
                rem_d   = '0;
                dvsr_d  = DW'(fl_q);
                dneg_d  = delta[GW];
                cnt_d   = CW'(GW);
                state_d = agr_pkg::ST_RDIV;
              end else begin
                acc_d   = {(AW-GW)'(0), cur_q};
                cnt_d   = CW'(GW);
                state_d = agr_pkg::ST_MUL;
              end
            end
            default: begin
            end
          endcase
        end
      end

      agr_pkg::ST_GDIV: begin
        if (cnt_q != '0) begin
          rq_d  = rq_step;
          rem_d = rem_step;
          cnt_d = cnt_q - 1'b1;
        end else begin
          apply_en  = 1'b1;
          apply_g   = rq_q[GW-1:0];
          apply_cmd = cmd_q;
          state_d   = agr_pkg::ST_IDLE;
        end
      end

      agr_pkg::ST_RDIV: begin
        if (cnt_q != '0) begin
          rq_d  = rq_step;
          rem_d = rem_step;
          cnt_d = cnt_q - 1'b1;
        end else begin
          fl_d    = fl_dec;
          cur_d   = (fl_dec == '0) ? tgt_q : new_cur;
          acc_d   = {(AW-GW)'(0), ((fl_dec == '0) ? tgt_q : new_cur)};
          cnt_d   = CW'(GW);
          state_d = agr_pkg::ST_MUL;
        end
      end

      agr_pkg::ST_MUL: begin
        if (cnt_q != '0) begin
          acc_d = acc_step;
          cnt_d = cnt_q - 1'b1;
        end else if (out_free) begin
          sout_d      = res_val[SW-1:0];
          gout_d      = cur_q;
          rout_d      = (fl_q != '0);
          out_valid_d = 1'b1;
          state_d     = agr_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = agr_pkg::ST_IDLE;
      end
    endcase

    if (apply_en) begin
      if (apply_cmd == agr_pkg::CMD_INIT) begin
        cur_d = apply_g;
        tgt_d = apply_g;
        fl_d  = '0;
      end else if (!(apply_g == tgt_q && fl_q != '0)) begin
        tgt_d = apply_g;
        fl_d  = (apply_g == cur_q) ? '0 : FW'(agr_pkg::RAMP_FRAMES);
      end
    end
  end

endmodule

`default_nettype wire
